FILE: src/expiring_credit_earliest_deadline_defines.svh
// assertion macros shared by the expiring credit blocks
// needs clk and rst_n in the scope that uses them
`ifndef EXPIRING_CREDIT_EARLIEST_DEADLINE_DEFINES_SVH
`define EXPIRING_CREDIT_EARLIEST_DEADLINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ECD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ECD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ecd_pkg.sv
// shared types, constants and a helper function for the expiring credit store
// no dependencies
package ecd_pkg;

  localparam int ECD_DEPTH   = 64;
  localparam int CNT_W       = 16;
  localparam int LIFE_W      = 7;
  localparam int BUCKET_W    = 32;
  localparam int TOTAL_W     = 32;
  localparam int GROUP_W     = 64;
  localparam int GIDX_W      = 6;

  typedef struct packed {
    logic accept;    // latch a new tick, read its add bucket
    logic add;       // add credits, build group flags
    logic pick;      // choose earliest bucket, read it
    logic dec;       // take one credit, expire current slot
    logic out_now;   // load output straight from the dec step
    logic out_hold;  // load output from the held result
  } ecd_cmd_t;

  // index of the lowest set bit, zero when none
  function automatic logic [GIDX_W-1:0] ecd_first_set(input logic [GROUP_W-1:0] v);
    logic [GIDX_W-1:0] idx;
    idx = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = GIDX_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: src/ecd_in_if.sv
// tick input channel: valid/ready handshake with credit count and shelf life
// depends on ecd_pkg
interface ecd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ecd_pkg::CNT_W-1:0]     credit_count;
  logic [ecd_pkg::LIFE_W-1:0]    shelf_life;

  modport source (output valid, credit_count, shelf_life, input ready);
  modport sink   (input valid, credit_count, shelf_life, output ready);
endinterface

FILE: src/ecd_out_if.sv
// result channel: valid/ready handshake with use flag, total and empty flag
// depends on ecd_pkg
interface ecd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          used_one;
  logic [ecd_pkg::TOTAL_W-1:0]   total_used;
  logic                          store_empty;

  modport source (output valid, used_one, total_used, store_empty, input ready);
  modport sink   (input valid, used_one, total_used, store_empty, output ready);
endinterface

FILE: src/ecd_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module ecd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ecd_ctrl.sv
// tick sequencer: accept, add, pick, decrement, then hand off the result
// depends on ecd_pkg and the assertion macro header
`include "expiring_credit_earliest_deadline_defines.svh"

module ecd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output ecd_pkg::ecd_cmd_t cmd
);
  import ecd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_PICK = 5'b00100,
    S_DEC  = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        if (out_free) begin
          cmd.out_now = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          cmd.out_hold = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_now || cmd.out_hold) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ECD_ASSERT_NEXT(a_accept_goes_add, in_valid && in_ready, state_r == S_ADD, "accept did not start add")
  `ECD_ASSERT_NOW(a_wait_has_output, state_r == S_WAIT, out_valid_r, "waiting without a pending output")

endmodule

FILE: src/ecd_dpath.sv
// bucket ram, nonempty map, tick pointer, running total and output registers
// depends on ecd_pkg, ecd_ram and the assertion macro header
`include "expiring_credit_earliest_deadline_defines.svh"

module ecd_dpath #(
  parameter int DEPTH = ecd_pkg::ECD_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ecd_pkg::ecd_cmd_t            cmd,
  input  logic [ecd_pkg::CNT_W-1:0]    in_count,
  input  logic [ecd_pkg::LIFE_W-1:0]   in_life,
  output logic                         res_used,
  output logic [ecd_pkg::TOTAL_W-1:0]  res_total,
  output logic                         res_empty
);
  import ecd_pkg::*;

  localparam int PW  = $clog2(DEPTH);
  localparam int NG  = (DEPTH + GROUP_W - 1) / GROUP_W;
  localparam int PAD = NG * GROUP_W;
  localparam int SW  = ((PW > LIFE_W) ? PW : LIFE_W) + 1;

  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic [PAD-1:0]       map_r, map_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]     count_r;
  logic                 add_en_r;
  logic [PW-1:0]        add_slot_r;
  logic [GROUP_W-1:0]   gm_r, ga_r;
  logic                 found_r;
  logic [PW-1:0]        pick_slot_r;
  logic                 out_used_r, out_empty_r, hold_used_r, hold_empty_r;
  logic [TOTAL_W-1:0]   out_total_r;

  // add slot from the incoming tick
  logic [SW-1:0]        life_ext, life_eff, slot_sum;
  logic [PW-1:0]        add_slot;
  logic                 add_en;

  always_comb begin
    life_ext = SW'(in_life);
    life_eff = (life_ext > SW'(DEPTH)) ? SW'(DEPTH) : life_ext;
    slot_sum = SW'(ptr_r) + life_eff - SW'(1);
    if (slot_sum >= SW'(DEPTH)) begin
      slot_sum = slot_sum - SW'(DEPTH);
    end
    add_slot = slot_sum[PW-1:0];
    add_en   = (in_count != '0) && (in_life != '0);
  end

  // ram ports
  logic                 ram_we, ram_re;
  logic [PW-1:0]        ram_waddr, ram_raddr;
  logic [BUCKET_W-1:0]  ram_wdata, ram_rdata;

  ecd_ram #(.WIDTH(BUCKET_W), .DEPTH(DEPTH)) u_buckets (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // add step: saturating add, map bit and group flags
  logic [BUCKET_W-1:0]  old_val;
  logic [BUCKET_W:0]    add_sum;
  logic [BUCKET_W-1:0]  add_val;
  logic [PAD-1:0]       map_add, mask;
  logic [GROUP_W-1:0]   gm_nxt, ga_nxt;

  always_comb begin
    old_val = map_r[add_slot_r] ? ram_rdata : '0;
    add_sum = {1'b0, old_val} + (BUCKET_W + 1)'(count_r);
    add_val = add_sum[BUCKET_W] ? '1 : add_sum[BUCKET_W-1:0];
    map_add = map_r;
    if (add_en_r) begin
      map_add[add_slot_r] = 1'b1;
    end
    mask   = {PAD{1'b1}} << ptr_r;
    gm_nxt = '0;
    ga_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      gm_nxt[g] = |(map_add[g*GROUP_W +: GROUP_W] & mask[g*GROUP_W +: GROUP_W]);
      ga_nxt[g] = |map_add[g*GROUP_W +: GROUP_W];
    end
  end

  // pick step: earliest group at or after the pointer, else wrap around
  logic                 any_late, pick_found;
  logic [GROUP_W-1:0]   flags, grp_bits, grp_mask;
  logic [GIDX_W-1:0]    grp_idx, bit_idx;
  logic [2*GIDX_W-1:0]  pick_full;
  logic [PW-1:0]        pick_slot;

  always_comb begin
    any_late   = |gm_r;
    flags      = any_late ? gm_r : ga_r;
    pick_found = |flags;
    grp_idx    = ecd_first_set(flags);
    grp_bits   = map_r[grp_idx*GROUP_W +: GROUP_W];
    grp_mask   = any_late ? mask[grp_idx*GROUP_W +: GROUP_W] : '1;
    bit_idx    = ecd_first_set(grp_bits & grp_mask);
    pick_full  = {grp_idx, bit_idx};
    pick_slot  = pick_full[PW-1:0];
  end

  // dec step: take one credit, expire the current slot
  logic [BUCKET_W-1:0]  dec_val;
  logic [PAD-1:0]       map_dec;
  logic                 dec_empty;

  always_comb begin
    dec_val = ram_rdata - BUCKET_W'(1);
    map_dec = map_r;
    if (found_r && (dec_val == '0)) begin
      map_dec[pick_slot_r] = 1'b0;
    end
    map_dec[ptr_r] = 1'b0;
    dec_empty      = ~|map_dec;
  end

  always_comb begin
    ram_re    = cmd.accept || cmd.pick;
    ram_raddr = cmd.accept ? add_slot : pick_slot;
    ram_we    = (cmd.add && add_en_r) || (cmd.dec && found_r);
    ram_waddr = cmd.dec ? pick_slot_r : add_slot_r;
    ram_wdata = cmd.dec ? dec_val : add_val;
  end

  always_comb begin
    map_nxt   = map_r;
    ptr_nxt   = ptr_r;
    total_nxt = total_r;
    if (cmd.add) begin
      map_nxt = map_add;
    end
    if (cmd.dec) begin
      map_nxt = map_dec;
      ptr_nxt = (ptr_r == PW'(DEPTH - 1)) ? '0 : ptr_r + PW'(1);
      if (found_r && (total_r != '1)) begin
        total_nxt = total_r + TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r   <= '0;
      ptr_r   <= '0;
      total_r <= '0;
    end else begin
      map_r   <= map_nxt;
      ptr_r   <= ptr_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      count_r    <= in_count;
      add_en_r   <= add_en;
      add_slot_r <= add_slot;
    end
    if (cmd.add) begin
      gm_r <= gm_nxt;
      ga_r <= ga_nxt;
    end
    if (cmd.pick) begin
      found_r     <= pick_found;
      pick_slot_r <= pick_slot;
    end
    if (cmd.dec) begin
      hold_used_r  <= found_r;
      hold_empty_r <= dec_empty;
    end
    if (cmd.out_now) begin
      out_used_r  <= found_r;
      out_total_r <= total_nxt;
      out_empty_r <= dec_empty;
    end else if (cmd.out_hold) begin
      out_used_r  <= hold_used_r;
      out_total_r <= total_r;
      out_empty_r <= hold_empty_r;
    end
  end

  assign res_used  = out_used_r;
  assign res_total = out_total_r;
  assign res_empty = out_empty_r;

  `ECD_ASSERT_NEXT(a_now_slot_expired, cmd.dec, !map_r[$past(ptr_r)], "current slot not cleared")
  `ECD_ASSERT_NEXT(a_total_monotonic, cmd.dec, total_r >= $past(total_r), "total went backwards")

endmodule

FILE: src/expiring_credit_earliest_deadline.sv
// a tick steps through add, pick and dec; the result loads at the end of dec when the
// output register is free; a new tick is taken only in idle, after two read-modify-writes
// of the bucket ram plus the group-then-bit search of the nonempty map between them
// reset: synchronous active-low rst_n clears the map, tick pointer, total and sequencer
// bucket ram is not cleared; a clear map bit marks its entry as zero
module expiring_credit_earliest_deadline #(
  parameter int DEPTH = ecd_pkg::ECD_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  ecd_in_if.sink        in_ch,
  ecd_out_if.source     out_ch
);
  import ecd_pkg::*;

  ecd_cmd_t cmd;

  ecd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  ecd_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_count  (in_ch.credit_count),
    .in_life   (in_ch.shelf_life),
    .res_used  (out_ch.used_one),
    .res_total (out_ch.total_used),
    .res_empty (out_ch.store_empty)
  );

endmodule

FILE: bench/expiring_credit_earliest_deadline_tb.sv
// testbench for the expiring credit store with earliest-deadline use
// drives ticks and predicts each result with a bucket ring of its own
// depends on ecd_pkg, ecd_in_if, ecd_out_if and expiring_credit_earliest_deadline
module expiring_credit_earliest_deadline_tb;
  import ecd_pkg::*;

  typedef struct packed {
    logic               used_one;
    logic [TOTAL_W-1:0] total_used;
    logic               store_empty;
  } tick_result_t;

  logic clk;
  logic rst_n;

  ecd_in_if  in_ch();
  ecd_out_if out_ch();

  expiring_credit_earliest_deadline dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted credit store
  logic [BUCKET_W-1:0] bucket_level [ECD_DEPTH];
  logic [ECD_DEPTH-1:0] live_slots;
  int unsigned          now_slot;
  logic [TOTAL_W-1:0]   spent_total;

  tick_result_t expected_results[$];
  int           mismatch_count;
  int           ticks_sent;
  bit           steady;
  bit           tick_driven;

  always #2 clk = ~clk;

  // one tick of the credit store: add, use the earliest credit, expire the current slot
  function automatic tick_result_t spend_earliest(input logic [CNT_W-1:0] cnt,
                                                  input logic [LIFE_W-1:0] life);
    int unsigned  span;
    int unsigned  slot;
    logic [BUCKET_W-1:0] room;
    tick_result_t r;
    span = (life > ECD_DEPTH) ? ECD_DEPTH : life;
    r.used_one = 1'b0;
    if (cnt != 0 && span != 0) begin
      slot = (now_slot + span - 1) % ECD_DEPTH;
      room = '1 - bucket_level[slot];
      bucket_level[slot] += (BUCKET_W'(cnt) > room) ? room : BUCKET_W'(cnt);
      live_slots[slot] = (bucket_level[slot] != 0);
    end
    for (int k = 0; k < ECD_DEPTH; k++) begin
      slot = (now_slot + k) % ECD_DEPTH;
      if (!r.used_one && live_slots[slot]) begin
        bucket_level[slot] -= 1;
        live_slots[slot] = (bucket_level[slot] != 0);
        r.used_one = 1'b1;
      end
    end
    if (r.used_one && spent_total != '1) spent_total += 1;
    bucket_level[now_slot] = '0;
    live_slots[now_slot] = 1'b0;
    now_slot = (now_slot + 1) % ECD_DEPTH;
    r.total_used = spent_total;
    r.store_empty = (live_slots == '0);
    return r;
  endfunction

  // leaves valid high after the transfer unless an idle gap follows
  task automatic send_tick(input logic [CNT_W-1:0] cnt, input logic [LIFE_W-1:0] life);
    in_ch.valid        <= 1'b1;
    in_ch.credit_count <= cnt;
    in_ch.shelf_life   <= life;
    tick_driven = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.insert(expected_results.size(), spend_earliest(cnt, life));
    ticks_sent++;
    if (!steady && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      tick_driven = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
  endtask

  task automatic stop_ticks();
    if (tick_driven) begin
      in_ch.valid <= 1'b0;
      tick_driven = 1'b0;
    end
  endtask

  task automatic settle_results();
    stop_ticks();
    do @(negedge clk); while (expected_results.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [CNT_W-1:0] rand_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return CNT_W'($urandom_range(3));
    if (pick < 80) return CNT_W'($urandom_range(40, 4));
    if (pick < 90) return '0;
    return CNT_W'($urandom);
  endfunction

  function automatic logic [LIFE_W-1:0] rand_life();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return LIFE_W'($urandom_range(ECD_DEPTH, 1));
    if (pick < 80) return LIFE_W'($urandom_range(4, 1));
    if (pick < 90) return '0;
    return LIFE_W'($urandom_range(127, ECD_DEPTH + 1));
  endfunction

  // zero ticks until no credit is left
  task automatic test_drain();
    while (live_slots != '0) send_tick('0, LIFE_W'($urandom));
  endtask

  task automatic test_nothing_added();
    send_tick('0, '0);
    send_tick(CNT_W'(9), '0);
    send_tick('0, LIFE_W'(ECD_DEPTH));
    send_tick('0, LIFE_W'(127));
  endtask

  task automatic test_field_extremes();
    send_tick(CNT_W'(1), LIFE_W'(1));
    send_tick('1, LIFE_W'(ECD_DEPTH));
    send_tick('1, '1);
    send_tick(CNT_W'(16'hAAAA), LIFE_W'(7'h55));
    send_tick(CNT_W'(16'h5555), LIFE_W'(7'h2A));
    send_tick(CNT_W'(3), LIFE_W'(ECD_DEPTH + 1));
    send_tick(CNT_W'(1), LIFE_W'(ECD_DEPTH - 1));
    test_drain();
  endtask

  // short deadlines must be served before the longer ones already stored
  task automatic test_deadline_order();
    send_tick(CNT_W'(2), LIFE_W'(10));
    send_tick(CNT_W'(1), LIFE_W'(3));
    send_tick(CNT_W'(1), LIFE_W'(2));
    send_tick('0, '0);
    send_tick('0, '0);
    test_drain();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (200) send_tick(rand_count(), rand_life());
    test_drain();
    steady = 1'b0;
  endtask

  task automatic test_one_at_a_time();
    repeat (40) begin
      send_tick(rand_count(), rand_life());
      settle_results();
    end
  endtask

  task automatic test_random_bursts();
    int unsigned pick;
    while (ticks_sent < 1650) begin
      repeat ($urandom_range(24, 1)) send_tick(rand_count(), rand_life());
      pick = $urandom_range(99);
      if (pick < 30) test_drain();
      else if (pick < 38) settle_results();
    end
    test_drain();
  endtask

  always @(posedge clk) begin : check_result
    tick_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no tick outstanding");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.used_one !== want.used_one) begin
          $error("used_one: expected %0d, got %0d", want.used_one, out_ch.used_one);
          mismatch_count++;
        end
        if (out_ch.total_used !== want.total_used) begin
          $error("total_used: expected %0d, got %0d", want.total_used, out_ch.total_used);
          mismatch_count++;
        end
        if (out_ch.store_empty !== want.store_empty) begin
          $error("store_empty: expected %0d, got %0d", want.store_empty, out_ch.store_empty);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) out_ch.ready <= steady || ($urandom_range(99) >= 22);

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.credit_count = '0;
    in_ch.shelf_life = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < ECD_DEPTH; i++) bucket_level[i] = '0;
    live_slots = '0;
    now_slot = 0;
    spent_total = '0;
    mismatch_count = 0;
    ticks_sent = 0;
    steady = 1'b0;
    tick_driven = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_nothing_added();
    test_field_extremes();
    test_deadline_order();
    test_back_to_back();
    test_one_at_a_time();
    test_random_bursts();

    settle_results();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
